// ----- src/ptd_pkg.sv -----
// Shared types, codes and constants for the periodic task dispatcher.
package ptd_pkg;

  localparam int CMD_W      = 2;
  localparam int PERIOD_W   = 16;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 3;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DONE     = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DISPATCH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller -> datapath strobes
  typedef struct packed {
    logic tick;
    logic reg_task;
    logic done;
    logic scan_start;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic busy;
    logic total_nz;
    logic out_free;
    logic due;
    logic pend_v;
    logic scan_end;
  } dp_status_t;

endpackage

// ----- src/ptd_in_if.sv -----
// Input channel: command and period with valid/ready.
interface ptd_in_if import ptd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, command, period, input ready);
  modport sink   (input valid, command, period, output ready);
endinterface

// ----- src/ptd_out_if.sv -----
// Result channel: dispatch and registration results with valid/ready.
interface ptd_out_if import ptd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  task_index;
  logic [TIME_W-1:0] time_now;
  logic              last;

  modport source (output valid, kind, task_index, time_now, last, input ready);
  modport sink   (input valid, kind, task_index, time_now, last, output ready);
endinterface

// ----- src/ptd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ptd_ctrl.sv -----
// Sequencer: input acceptance, table scan stepping and round finish.
module ptd_ctrl import ptd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          unique case (in_command)
            CMD_TICK: begin
              cmd.tick = 1'b1;
              if (!status.busy && status.total_nz) begin
                cmd.scan_start = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
            CMD_REGISTER: cmd.reg_task = 1'b1;
            CMD_DONE:     cmd.done = 1'b1;
            default:      ;
          endcase
        end
      end
      ST_SCAN: begin
        // a second due task needs the held one pushed out first
        if (!(status.due && status.pend_v && !status.out_free)) begin
          cmd.scan_step = 1'b1;
          if (status.scan_end) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!status.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- src/ptd_dp.sv -----
// Datapath: clock, task table, due check, held dispatch and result register.
module ptd_dp import ptd_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  input  logic [PERIOD_W-1:0] in_period,
  output dp_status_t          status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic [IDX_W-1:0]    out_task_index,
  output logic [TIME_W-1:0]   out_time_now,
  output logic                out_last
);

  localparam int IW      = TASK_SLOTS > 1 ? $clog2(TASK_SLOTS) : 1;
  localparam int TW      = $clog2(TASK_SLOTS + 1);
  localparam int ENTRY_W = PERIOD_W + TIME_W;

  function automatic logic [IDX_W-1:0] idx_out(input logic [IW-1:0] i);
    logic [IW+IDX_W-1:0] e;
    e = (IW + IDX_W)'(i);
    return e[IDX_W-1:0];
  endfunction

  logic [TIME_W-1:0] millis_r, millis_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic              busy_r, busy_nxt;
  logic [IW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              out_v_r, out_v_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [PERIOD_W-1:0] rd_period;
  logic [TIME_W-1:0]   rd_last;
  logic [TIME_W-1:0]   elapsed;
  logic [CNT_W-1:0]    cnt_inc;
  logic                due, full, scan_last, scan_end, out_free;

  ptd_ram #(.WIDTH(ENTRY_W), .DEPTH(TASK_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_period = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_last   = ram_rdata[TIME_W-1:0];
  assign elapsed   = millis_r - rd_last;   // wraps
  assign due       = elapsed >= TIME_W'(rd_period);
  assign full      = total_r == TW'(TASK_SLOTS);
  assign scan_last = (TW'(scan_idx_r) + TW'(1)) == total_r;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign scan_end  = scan_last || (due && cnt_inc == CNT_W'(MAX_RESULTS));
  assign out_free  = !out_v_r || out_ready;

  assign status.busy     = busy_r;
  assign status.total_nz = total_r != '0;
  assign status.out_free = out_free;
  assign status.due      = due;
  assign status.pend_v   = pend_v_r;
  assign status.scan_end = scan_end;

  // table write: new entry on register, last-run update on dispatch
  always_comb begin
    ram_we    = (cmd.reg_task && !full) || (cmd.scan_step && due);
    ram_waddr = cmd.reg_task ? total_r[IW-1:0] : scan_idx_r;
    ram_wdata = cmd.reg_task ? {in_period, {TIME_W{1'b0}}} : {rd_period, millis_r};
    if (cmd.scan_start) begin
      ram_raddr = '0;
    end else if (cmd.scan_step && !scan_end) begin
      ram_raddr = scan_idx_r + IW'(1);
    end else begin
      ram_raddr = scan_idx_r;
    end
  end

  always_comb begin
    millis_nxt   = millis_r;
    total_nxt    = total_r;
    busy_nxt     = busy_r;
    scan_idx_nxt = scan_idx_r;
    cnt_nxt      = cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    out_v_nxt    = out_ready ? 1'b0 : out_v_r;
    out_kind_nxt = out_kind_r;
    out_idx_nxt  = out_idx_r;
    out_time_nxt = out_time_r;
    out_last_nxt = out_last_r;

    if (cmd.tick) begin
      millis_nxt = millis_r + TIME_W'(1);
    end
    if (cmd.done) begin
      busy_nxt = 1'b0;
    end
    if (cmd.reg_task) begin
      out_v_nxt    = 1'b1;
      out_time_nxt = millis_r;
      out_last_nxt = 1'b1;
      if (full) begin
        out_kind_nxt = KIND_FULL;
        out_idx_nxt  = '0;
      end else begin
        out_kind_nxt = KIND_REGISTERED;
        out_idx_nxt  = idx_out(total_r[IW-1:0]);
        total_nxt    = total_r + TW'(1);
      end
    end
    if (cmd.scan_start) begin
      scan_idx_nxt = '0;
      cnt_nxt      = '0;
      pend_v_nxt   = 1'b0;
    end
    if (cmd.scan_step) begin
      if (!scan_end) begin
        scan_idx_nxt = scan_idx_r + IW'(1);
      end
      if (due) begin
        // one dispatch is held back until we know whether it is the last
        if (pend_v_r) begin
          out_v_nxt    = 1'b1;
          out_kind_nxt = KIND_DISPATCH;
          out_idx_nxt  = idx_out(pend_idx_r);
          out_time_nxt = millis_r;
          out_last_nxt = 1'b0;
        end
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = scan_idx_r;
        cnt_nxt      = cnt_inc;
      end
    end
    if (cmd.finish) begin
      out_v_nxt    = 1'b1;
      out_kind_nxt = KIND_DISPATCH;
      out_idx_nxt  = idx_out(pend_idx_r);
      out_time_nxt = millis_r;
      out_last_nxt = 1'b1;
      busy_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      millis_r <= '0;
      total_r  <= '0;
      busy_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      millis_r <= millis_nxt;
      total_r  <= total_nxt;
      busy_r   <= busy_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cnt_r      <= cnt_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_kind       = out_kind_r;
  assign out_task_index = out_idx_r;
  assign out_time_now   = out_time_r;
  assign out_last       = out_last_r;

endmodule

// ----- src/periodic_task_dispatcher_top.sv -----
// Top level of the periodic task dispatcher: controller, datapath and channels.
//
// in_ch carries one command per transaction: tick (one millisecond), register
// a task with a period, or dispatch round done. out_ch carries the results:
// registration index or table full, and one dispatch per due task, the final
// result of each command flagged with last.
// A command is taken only while the block is idle and its result register is
// free or being emptied in the same cycle; one command is in work at a time.
// Register: one result, in the cycle after the transaction.
// Tick with a scan: the task table is a RAM read once per cycle unless a
// receiver stall halts the scan, which ends at the last registered task or
// at MAX_RESULTS due tasks; the next command can follow the final dispatch.
// Ticks while a round is outstanding, done and unused codes yield no result.
// A receiver stall holds the result register and halts the scan on the next
// due task until the register drains; nothing is dropped.
// Reset (synchronous, rst_n low) clears the clock, the task count and the
// busy flag; the table RAM needs no clearing since only registered entries
// are ever read.
module periodic_task_dispatcher_top import ptd_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptd_in_if.sink      in_ch,
  ptd_out_if.source   out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ptd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ptd_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_period      (in_ch.period),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_kind       (out_ch.kind),
    .out_task_index (out_ch.task_index),
    .out_time_now   (out_ch.time_now),
    .out_last       (out_ch.last)
  );

  // the closing dispatch of a round always comes with the round marked busy
  a_last_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_DISPATCH && out_ch.last) |-> status.busy)
    else $error("final dispatch shown without round busy");

  // a tick during an outstanding round yields no result
  a_busy_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_TICK && status.busy)
      |=> !out_ch.valid)
    else $error("result produced by tick while busy");

  // round done always releases the busy flag
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_DONE) |=> !status.busy)
    else $error("busy still set after round done");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the periodic task dispatcher: directed and random commands.
module tb;
  import ptd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TASK_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  task_index;
    logic [TIME_W-1:0] time_now;
    logic              last;
  } sched_result_t;

  logic clk;
  logic rst_n;

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  periodic_task_dispatcher_top #(.TASK_SLOTS(SLOTS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scheduler shadow state
  int                  sched_total;
  logic [PERIOD_W-1:0] sched_period [SLOTS];
  logic [TIME_W-1:0]   sched_last_run [SLOTS];
  logic [TIME_W-1:0]   sched_millis;
  logic                sched_busy;

  sched_result_t pending_results [$];
  int            error_count;
  int            cycle_count;
  bit            gapless;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void predict_results(input logic [CMD_W-1:0] cmd,
                                          input logic [PERIOD_W-1:0] per);
    sched_result_t     round [MAX_RESULTS];
    int                fired;
    logic [TIME_W-1:0] elapsed;
    fired = 0;
    case (cmd)
      CMD_TICK: begin
        sched_millis = sched_millis + 1'b1;
        if (!sched_busy) begin
          for (int i = 0; i < sched_total && fired < MAX_RESULTS; i++) begin
            elapsed = sched_millis - sched_last_run[i];
            if (elapsed >= TIME_W'(sched_period[i])) begin
              sched_last_run[i] = sched_millis;
              round[fired] = '{KIND_DISPATCH, IDX_W'(i), sched_millis, 1'b0};
              fired++;
            end
          end
          if (fired > 0) begin
            round[fired-1].last = 1'b1;
            sched_busy = 1'b1;
          end
          for (int k = 0; k < fired; k++) pending_results.push_back(round[k]);
        end
      end
      CMD_REGISTER: begin
        if (sched_total >= SLOTS) begin
          pending_results.push_back('{KIND_FULL, '0, sched_millis, 1'b1});
        end else begin
          sched_period[sched_total] = per;
          sched_last_run[sched_total] = '0;
          pending_results.push_back('{KIND_REGISTERED, IDX_W'(sched_total),
                                      sched_millis, 1'b1});
          sched_total++;
        end
      end
      CMD_DONE: sched_busy = 1'b0;
      default: ;
    endcase
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PERIOD_W-1:0] per);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.period  <= per;
    do @(posedge clk); while (!in_ch.ready);
    predict_results(cmd, per);
  endtask

  // result side: random stall per transaction, then compare with the oldest expectation
  initial begin
    int            stall;
    sched_result_t exp_r;
    wait (rst_n === 1'b1);
    forever begin
      stall = gapless ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d task_index %0d time_now %0d last %0d",
               out_ch.kind, out_ch.task_index, out_ch.time_now, out_ch.last);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_ch.kind);
          error_count++;
        end
        if (out_ch.task_index !== exp_r.task_index) begin
          $error("task_index: expected %0d, got %0d", exp_r.task_index, out_ch.task_index);
          error_count++;
        end
        if (out_ch.time_now !== exp_r.time_now) begin
          $error("time_now: expected %0d, got %0d", exp_r.time_now, out_ch.time_now);
          error_count++;
        end
        if (out_ch.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // empty table, stray done and the unused code
  task automatic test_idle_commands();
    send_command(CMD_TICK, '0);
    send_command(CMD_DONE, '0);
    send_command(CMD_UNUSED, '1);
    send_command(CMD_TICK, '1);
  endtask

  // zero period is due on every scanning tick; busy blocks the scan
  task automatic test_zero_period_round();
    send_command(CMD_REGISTER, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_REGISTER, 16'd3);
    send_command(CMD_DONE, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_DONE, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_DONE, '0);
  endtask

  task automatic test_fill_table();
    send_command(CMD_REGISTER, 16'd1);
    send_command(CMD_REGISTER, 16'hFFFF);
    send_command(CMD_REGISTER, 16'd2);
    send_command(CMD_REGISTER, 16'd5);
    send_command(CMD_REGISTER, 16'h8000);
    send_command(CMD_REGISTER, 16'd7);
    send_command(CMD_REGISTER, 16'h5A5A);
    send_command(CMD_REGISTER, 16'hA5A5);
    send_command(CMD_TICK, '0);
    send_command(CMD_DONE, '0);
  endtask

  task automatic test_random_traffic(input int n_items, input bit tight);
    int               sent;
    int               pick;
    logic [CMD_W-1:0] cmd;
    gapless = tight;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_TICK;
      else if (pick < 80) cmd = CMD_DONE;
      else if (pick < 92) cmd = CMD_REGISTER;
      else cmd = CMD_UNUSED;
      send_command(cmd, PERIOD_W'($urandom_range(0, 65535)));
      sent++;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.period  = '0;
    out_ch.ready  = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    gapless       = 1'b0;
    sched_total   = 0;
    sched_millis  = '0;
    sched_busy    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      sched_period[i]   = '0;
      sched_last_run[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_zero_period_round();
    test_fill_table();
    test_random_traffic(100, 1'b0);
    test_random_traffic(67, 1'b1);
    test_random_traffic(20, 1'b0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
